[hw/rtl/rfr_pkg.sv]
// Control codes, character classes and helpers for the record frame receiver.
package rfr_pkg;

	localparam logic [7:0] CODE_HEADER = 8'h01;
	localparam logic [7:0] CODE_BODY   = 8'h02;
	localparam logic [7:0] CODE_FIELD  = 8'h03;
	localparam logic [7:0] CODE_RECORD = 8'h04;
	localparam logic [7:0] CODE_READ   = 8'h05;

	localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
	localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
	localparam logic [7:0] CHAR_UPPER_HI = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
	localparam logic [7:0] CHAR_LOWER_HI = 8'h7A;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_COMMA    = 8'h2C;

	typedef struct packed {
		logic        store_enable;
		logic [5:0]  store_index;
		logic [7:0]  store_char;
		logic [15:0] stored_count;
		logic [7:0]  record_number;
		logic        field_end;
		logic        start_write;
		logic        start_read;
	} rfr_result_t;

	function automatic logic is_body_char(input logic [7:0] c);
		return (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
			(c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
			(c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
			c == CHAR_SPACE || c == CHAR_COMMA;
	endfunction

endpackage

[hw/rtl/record_frame_receiver_unit.sv]
// Record frame receiver: control-code framing parser, one byte per transfer.
//
// Input channel: in_valid / in_stall with rx_byte. Output channel: out_valid /
// out_stall with the store, count, record number and action pulse fields.
// A transfer happens at a rising edge where valid is high and stall is low.
// Every input byte gives exactly one output transfer.
// The byte is held in the input register, then the parser rules and state
// update run in one combinational pass into the result register, which drives
// the outputs. With no stall the block takes one byte every cycle.
// When the receiver stalls, the result register holds its item and the input
// register fills; in_stall rises only when both stages are full, so at most
// two bytes are in flight.
// Reset clears the parser state, the character count, the record number and
// both stage valid flags; the block takes bytes in the first cycle after reset.
// BUFFER_DEPTH sets where the write position wraps; store_index carries its
// low 6 bits.
module record_frame_receiver_unit
	import rfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        store_enable,
	output logic [5:0]  store_index,
	output logic [7:0]  store_char,
	output logic [15:0] stored_count,
	output logic [7:0]  record_number,
	output logic        field_end,
	output logic        start_write,
	output logic        start_read
);

	localparam int PosW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            valid_s2;
	rfr_result_t     result_s2;
	logic            advance;

	logic [PosW-1:0] write_pos_q;
	logic            header_open_q;
	logic            header_done_q;
	logic            body_open_q;
	logic            body_has_data_q;
	logic [15:0]     char_count_q;
	logic [7:0]      record_q;

	logic [PosW-1:0] write_pos_d;
	logic            header_open_d;
	logic            header_done_d;
	logic            body_open_d;
	logic            body_has_data_d;
	logic [15:0]     char_count_d;
	logic [7:0]      record_d;
	rfr_result_t     result_d;
	logic [7:0]      pos_ext;
	logic [8:0]      pos_inc;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign pos_ext = 8'(write_pos_q);
	assign pos_inc = {1'b0, pos_ext} + 9'd1;

	always_comb begin
		write_pos_d     = write_pos_q;
		header_open_d   = header_open_q;
		header_done_d   = header_done_q;
		body_open_d     = body_open_q;
		body_has_data_d = body_has_data_q;
		char_count_d    = char_count_q;
		record_d        = record_q;
		result_d        = '0;
		if (is_body_char(byte_s1) && body_open_q && header_done_q) begin
			result_d.store_enable = 1'b1;
			result_d.store_index  = pos_ext[5:0];
			result_d.store_char   = byte_s1;
			if (pos_inc >= 9'(BUFFER_DEPTH)) begin
				write_pos_d = '0;
			end else begin
				write_pos_d = pos_inc[PosW-1:0];
			end
			char_count_d    = char_count_q + 16'd1;
			body_has_data_d = 1'b1;
		end else if (byte_s1 == CODE_READ && header_done_q) begin
			result_d.start_read = 1'b1;
			header_done_d       = 1'b0;
		end else if (byte_s1 == CODE_RECORD && body_has_data_q) begin
			write_pos_d          = '0;
			result_d.field_end   = 1'b1;
			result_d.start_write = 1'b1;
			body_open_d          = 1'b0;
			header_done_d        = 1'b0;
			body_has_data_d      = 1'b0;
		end else if (byte_s1 == CODE_FIELD && body_has_data_q) begin
			write_pos_d        = '0;
			result_d.field_end = 1'b1;
			body_has_data_d    = 1'b0;
		end else if (byte_s1 == CODE_BODY && header_done_q) begin
			body_open_d = 1'b1;
		end else if (byte_s1 == CODE_HEADER && !header_done_q && !header_open_q) begin
			header_open_d = 1'b1;
		end else if (header_open_q && !header_done_q) begin
			record_d      = byte_s1;
			header_open_d = 1'b0;
			header_done_d = 1'b1;
		end
		result_d.stored_count  = char_count_d;
		result_d.record_number = record_d;
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state: advance on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q     <= '0;
			header_open_q   <= 1'b0;
			header_done_q   <= 1'b0;
			body_open_q     <= 1'b0;
			body_has_data_q <= 1'b0;
			char_count_q    <= '0;
			record_q        <= '0;
		end else if (advance) begin
			write_pos_q     <= write_pos_d;
			header_open_q   <= header_open_d;
			header_done_q   <= header_done_d;
			body_open_q     <= body_open_d;
			body_has_data_q <= body_has_data_d;
			char_count_q    <= char_count_d;
			record_q        <= record_d;
		end
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid     = valid_s2;
	assign store_enable  = result_s2.store_enable;
	assign store_index   = result_s2.store_index;
	assign store_char    = result_s2.store_char;
	assign stored_count  = result_s2.stored_count;
	assign record_number = result_s2.record_number;
	assign field_end     = result_s2.field_end;
	assign start_write   = result_s2.start_write;
	assign start_read    = result_s2.start_read;

	a_write_has_field_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && start_write |-> field_end)
		else $error("start_write without field_end");

	a_store_excludes_actions: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && store_enable |-> !field_end && !start_read)
		else $error("character write combined with an action pulse");

	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && start_read |-> !field_end && !start_write)
		else $error("start_read combined with field end");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while a stage is free");

	a_count_tracks_store: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !result_d.store_enable |=> char_count_q == $past(char_count_q))
		else $error("character count moved without a store");

endmodule

[tb/sv/frame_parse_checker.sv]
// Checker for the record frame receiver: predicts each output transfer and compares it.
module frame_parse_checker
	import rfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        store_enable,
	input  logic [5:0]  store_index,
	input  logic [7:0]  store_char,
	input  logic [15:0] stored_count,
	input  logic [7:0]  record_number,
	input  logic        field_end,
	input  logic        start_write,
	input  logic        start_read,
	output int          fail_count,
	output int          outstanding
);

	int unsigned wr_pos;
	logic        hdr_open;
	logic        hdr_done;
	logic        body_live;
	logic        body_filled;
	logic [15:0] chars_stored;
	logic [7:0]  rec_num;
	int          mismatches;
	rfr_result_t want;
	rfr_result_t expected_results[$];

	function automatic logic is_text_byte(input logic [7:0] b);
		if (b == CHAR_SPACE || b == CHAR_COMMA)
			return 1'b1;
		if (b < CHAR_DIGIT_LO || b > CHAR_LOWER_HI)
			return 1'b0;
		return (b <= CHAR_DIGIT_HI) || (b >= CHAR_UPPER_LO && b <= CHAR_UPPER_HI) ||
			(b >= CHAR_LOWER_LO);
	endfunction

	function automatic rfr_result_t predict_frame_step(input logic [7:0] b);
		rfr_result_t r;
		r = '0;
		if (is_text_byte(b) && body_live && hdr_done) begin
			r.store_enable = 1'b1;
			r.store_index = 6'(wr_pos);
			r.store_char = b;
			wr_pos = (wr_pos + 1 >= BUFFER_DEPTH) ? 0 : wr_pos + 1;
			chars_stored = chars_stored + 16'd1;
			body_filled = 1'b1;
		end else if (b == CODE_READ && hdr_done) begin
			r.start_read = 1'b1;
			hdr_done = 1'b0;
		end else if (b == CODE_RECORD && body_filled) begin
			r.field_end = 1'b1;
			r.start_write = 1'b1;
			wr_pos = 0;
			body_live = 1'b0;
			hdr_done = 1'b0;
			body_filled = 1'b0;
		end else if (b == CODE_FIELD && body_filled) begin
			r.field_end = 1'b1;
			wr_pos = 0;
			body_filled = 1'b0;
		end else if (b == CODE_BODY && hdr_done) begin
			body_live = 1'b1;
		end else if (b == CODE_HEADER && !hdr_done && !hdr_open) begin
			hdr_open = 1'b1;
		end else if (hdr_open && !hdr_done) begin
			rec_num = b;
			hdr_open = 1'b0;
			hdr_done = 1'b1;
		end
		r.stored_count = chars_stored;
		r.record_number = rec_num;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want_val);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch on %s: got %0h, want %0h", what, got, want_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos = 0;
			hdr_open = 1'b0;
			hdr_done = 1'b0;
			body_live = 1'b0;
			body_filled = 1'b0;
			chars_stored = '0;
			rec_num = '0;
			mismatches = 0;
			expected_results.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("output transfer with nothing outstanding", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (store_enable !== want.store_enable)
						report_mismatch("store_enable", store_enable, want.store_enable);
					if (store_index !== want.store_index)
						report_mismatch("store_index", store_index, want.store_index);
					if (store_char !== want.store_char)
						report_mismatch("store_char", store_char, want.store_char);
					if (stored_count !== want.stored_count)
						report_mismatch("stored_count", stored_count, want.stored_count);
					if (record_number !== want.record_number)
						report_mismatch("record_number", record_number, want.record_number);
					if (field_end !== want.field_end)
						report_mismatch("field_end", field_end, want.field_end);
					if (start_write !== want.start_write)
						report_mismatch("start_write", start_write, want.start_write);
					if (start_read !== want.start_read)
						report_mismatch("start_read", start_read, want.start_read);
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_frame_step(rx_byte));
			fail_count <= mismatches;
			outstanding <= expected_results.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the record frame receiver testbench: clock, reset, byte stimulus and verdict.
module testbench;
	import rfr_pkg::*;

	localparam int ITEM_TOTAL  = 1450;
	localparam int CALM_FROM   = 1300;
	localparam int HOLD_AT     = 400;
	localparam int DRAIN_AT    = 800;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        store_enable;
	logic [5:0]  store_index;
	logic [7:0]  store_char;
	logic [15:0] stored_count;
	logic [7:0]  record_number;
	logic        field_end;
	logic        start_write;
	logic        start_read;
	int          fail_count;
	int          outstanding;

	int          sent_count;
	int          cycle_count;
	bit          calm;
	bit          hold_request;
	bit          hold_served;
	bit          drain_done;

	logic [7:0] directed_bytes [0:25] = '{
		8'h00, 8'hFF, CODE_BODY, CODE_FIELD, CODE_RECORD, CODE_READ,
		CODE_HEADER, CODE_HEADER, CODE_READ,
		CODE_HEADER, 8'hFF, CODE_BODY,
		CHAR_DIGIT_LO, CHAR_DIGIT_HI, CHAR_UPPER_LO, CHAR_UPPER_HI,
		CHAR_LOWER_LO, CHAR_LOWER_HI, CHAR_SPACE, CHAR_COMMA,
		8'h80, CODE_FIELD, 8'h2F, CODE_RECORD, CHAR_UPPER_HI, CODE_RECORD
	};

	record_frame_receiver_unit dut (.*);

	frame_parse_checker parse_check (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (calm ? 1 : ($urandom_range(0, 7) == 0 ? 30 : $urandom_range(1, 6)))
					@(posedge clk);
			end
		end
	end

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 4))
			0: return 8'(CHAR_DIGIT_LO + $urandom_range(0, 9));
			1: return 8'(CHAR_UPPER_LO + $urandom_range(0, 25));
			2: return 8'(CHAR_LOWER_LO + $urandom_range(0, 25));
			3: return CHAR_SPACE;
			default: return CHAR_COMMA;
		endcase
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		if (sent_count >= CALM_FROM)
			calm = 1'b1;
		if (sent_count >= HOLD_AT)
			hold_request = 1'b1;
		if (sent_count >= DRAIN_AT && !drain_done) begin
			drain_done = 1'b1;
			in_valid <= 1'b0;
			wait_drained();
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		int kind;
		int nfields;
		int len;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
			return;
		end
		push_byte(CODE_HEADER);
		push_byte(8'($urandom_range(0, 255)));
		if (kind == 1)
			return;
		if (kind == 2) begin
			push_byte(CODE_READ);
			return;
		end
		push_byte(CODE_BODY);
		nfields = $urandom_range(1, 3);
		for (int f = 0; f < nfields; f++) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 12);
			for (int i = 0; i < len; i++)
				push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: pick_text_byte());
			if (f < nfields - 1)
				push_byte(CODE_FIELD);
		end
		if (kind != 3)
			push_byte(CODE_RECORD);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		sent_count = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		hold_served = 1'b0;
		drain_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);
		while (sent_count < ITEM_TOTAL)
			send_frame();
		in_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
